>>> hdl/clt_pkg.sv
// Package with the types, character codes and result codes of the command line tokenizer.
package clt_pkg;

  typedef enum logic [9:0] {
    PH_LEAD  = 10'b00_0000_0001,
    PH_COL1  = 10'b00_0000_0010,
    PH_WS1   = 10'b00_0000_0100,
    PH_COL2  = 10'b00_0000_1000,
    PH_WS2   = 10'b00_0001_0000,
    PH_NAME  = 10'b00_0010_0000,
    PH_AFTER = 10'b00_0100_0000,
    PH_ARGS  = 10'b00_1000_0000,
    PH_DONE  = 10'b01_0000_0000,
    PH_BAD   = 10'b10_0000_0000
  } phase_t;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_NAME = 2'd1;
  localparam logic [1:0] KIND_ARG  = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_PAREN = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [7:0] POS_MAX = 8'hFF;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

>>> hdl/clt_if.sv
// Valid/ready channel interfaces for the text byte input and the token result output.
interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface clt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [7:0] byte_position;
  logic [1:0] status;
  logic [7:0] name_length;
  logic [7:0] args_length;
  logic       has_args;

  modport source (output valid, output kind, output out_byte, output byte_position,
                  output status, output name_length, output args_length,
                  output has_args, input ready);
  modport sink (input valid, input kind, input out_byte, input byte_position,
                input status, input name_length, input args_length,
                input has_args, output ready);
endinterface

>>> hdl/command_line_tokenizer_core.sv
// Top level of the command line tokenizer: byte-wise line parser with a registered result.
//
// The block takes one byte of a text line per request on in_ch; a zero byte ends the line.
// Every accepted byte produces exactly one result request on out_ch: nothing, a name byte,
// an argument byte with its position, or at the terminator a summary with status, name
// length, argument length and the has_args flag.
// The result of a byte is in the output register in the cycle after it is accepted.
// Throughput is one byte per clock while the receiver keeps out_ch.ready high, set by the
// single parse state update that sits between the input handshake and the output register.
// When the receiver stalls, the output register holds its result and in_ch.ready stays
// high only if the waiting result is taken in the same cycle, so no result is lost.
// Reset (rst_n low, synchronous) returns the parser to the leading whitespace phase,
// clears all counters and empties the output register. The parser also returns to that
// state after each terminator, so lines follow one another without gaps.
module command_line_tokenizer_core #(
  parameter int LINE_MAX_CHARS = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  clt_in_if.sink          in_ch,
  clt_out_if.source       out_ch
);

  localparam int CNT_W = $clog2(LINE_MAX_CHARS + 1);
  localparam logic [CNT_W-1:0] LB_FULL = CNT_W'(LINE_MAX_CHARS);
  localparam logic [CNT_W-1:0] LB_LAST = CNT_W'(LINE_MAX_CHARS - 1);

  clt_pkg::phase_t phase_r, phase_nxt;
  logic             in_quote_r, in_quote_nxt;
  logic [7:0]       name_count_r, name_count_nxt;
  logic [7:0]       arg_count_r, arg_count_nxt;
  logic [7:0]       qpos_r, qpos_nxt;
  logic             qseen_r, qseen_nxt;
  logic [CNT_W-1:0] line_bytes_r, line_bytes_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [1:0] status_r, status_nxt;
  logic [7:0] nlen_r, nlen_nxt;
  logic [7:0] alen_r, alen_nxt;
  logic       has_args_r, has_args_nxt;

  logic       acc;
  logic [7:0] c;
  logic       ws;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign c           = in_ch.text_byte;
  assign ws          = clt_pkg::is_ws(c);

  always_comb begin
    phase_nxt      = phase_r;
    in_quote_nxt   = in_quote_r;
    name_count_nxt = name_count_r;
    arg_count_nxt  = arg_count_r;
    qpos_nxt       = qpos_r;
    qseen_nxt      = qseen_r;
    line_bytes_nxt = line_bytes_r;
    kind_nxt       = clt_pkg::KIND_NONE;
    obyte_nxt      = 8'd0;
    pos_nxt        = 8'd0;
    status_nxt     = clt_pkg::STATUS_OK;
    nlen_nxt       = 8'd0;
    alen_nxt       = 8'd0;
    has_args_nxt   = 1'b0;

    if (c == clt_pkg::CH_NUL) begin
      kind_nxt     = clt_pkg::KIND_END;
      has_args_nxt = (phase_r == clt_pkg::PH_ARGS) || (phase_r == clt_pkg::PH_DONE);
      if (line_bytes_r >= LB_FULL) begin
        status_nxt = clt_pkg::STATUS_TOO_LONG;
      end else if ((phase_r == clt_pkg::PH_ARGS) || (phase_r == clt_pkg::PH_BAD)) begin
        status_nxt = clt_pkg::STATUS_NO_PAREN;
      end
      nlen_nxt = name_count_r;
      alen_nxt = ((phase_r == clt_pkg::PH_DONE) && qseen_r) ? qpos_r : arg_count_r;
      phase_nxt      = clt_pkg::PH_LEAD;
      in_quote_nxt   = 1'b0;
      name_count_nxt = 8'd0;
      arg_count_nxt  = 8'd0;
      qpos_nxt       = 8'd0;
      qseen_nxt      = 1'b0;
      line_bytes_nxt = '0;
    end else if (line_bytes_r >= LB_FULL) begin
      line_bytes_nxt = line_bytes_r;
    end else if (line_bytes_r >= LB_LAST) begin
      line_bytes_nxt = LB_FULL;
    end else begin
      line_bytes_nxt = line_bytes_r + CNT_W'(1);
      unique case (phase_r)
        clt_pkg::PH_LEAD: begin
          if (!ws) phase_nxt = clt_pkg::PH_COL1;
        end
        clt_pkg::PH_COL1: begin
          if (ws) phase_nxt = clt_pkg::PH_WS1;
        end
        clt_pkg::PH_WS1: begin
          if (!ws) phase_nxt = clt_pkg::PH_COL2;
        end
        clt_pkg::PH_COL2: begin
          if (ws) phase_nxt = clt_pkg::PH_WS2;
        end
        clt_pkg::PH_WS2, clt_pkg::PH_NAME: begin
          if (ws) begin
            if (phase_r == clt_pkg::PH_NAME) phase_nxt = clt_pkg::PH_AFTER;
          end else if (c == clt_pkg::CH_LPAREN) begin
            phase_nxt = clt_pkg::PH_ARGS;
          end else if (name_count_r == clt_pkg::POS_MAX) begin
            line_bytes_nxt = LB_FULL;
          end else begin
            kind_nxt       = clt_pkg::KIND_NAME;
            obyte_nxt      = c;
            pos_nxt        = name_count_r;
            name_count_nxt = name_count_r + 8'd1;
            phase_nxt      = clt_pkg::PH_NAME;
          end
        end
        clt_pkg::PH_AFTER: begin
          if (c == clt_pkg::CH_LPAREN) begin
            phase_nxt = clt_pkg::PH_ARGS;
          end else if (!ws) begin
            phase_nxt = clt_pkg::PH_BAD;
          end
        end
        clt_pkg::PH_ARGS: begin
          if (c == clt_pkg::CH_RPAREN) begin
            phase_nxt = clt_pkg::PH_DONE;
          end else if ((c == clt_pkg::CH_QUOTE) && !in_quote_r) begin
            in_quote_nxt = 1'b1;
          end else if (arg_count_r == clt_pkg::POS_MAX) begin
            line_bytes_nxt = LB_FULL;
          end else begin
            if (c == clt_pkg::CH_QUOTE) begin
              qpos_nxt  = arg_count_r;
              qseen_nxt = 1'b1;
            end
            kind_nxt      = clt_pkg::KIND_ARG;
            obyte_nxt     = (c == clt_pkg::CH_COMMA) ? clt_pkg::CH_SPACE : c;
            pos_nxt       = arg_count_r;
            arg_count_nxt = arg_count_r + 8'd1;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= clt_pkg::PH_LEAD;
      in_quote_r   <= 1'b0;
      name_count_r <= 8'd0;
      arg_count_r  <= 8'd0;
      qpos_r       <= 8'd0;
      qseen_r      <= 1'b0;
      line_bytes_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        phase_r      <= phase_nxt;
        in_quote_r   <= in_quote_nxt;
        name_count_r <= name_count_nxt;
        arg_count_r  <= arg_count_nxt;
        qpos_r       <= qpos_nxt;
        qseen_r      <= qseen_nxt;
        line_bytes_r <= line_bytes_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      kind_r     <= kind_nxt;
      obyte_r    <= obyte_nxt;
      pos_r      <= pos_nxt;
      status_r   <= status_nxt;
      nlen_r     <= nlen_nxt;
      alen_r     <= alen_nxt;
      has_args_r <= has_args_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.out_byte      = obyte_r;
  assign out_ch.byte_position = pos_r;
  assign out_ch.status        = status_r;
  assign out_ch.name_length   = nlen_r;
  assign out_ch.args_length   = alen_r;
  assign out_ch.has_args      = has_args_r;

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (c == clt_pkg::CH_NUL)) |=>
      ((phase_r == clt_pkg::PH_LEAD) && (line_bytes_r == '0) && !qseen_r))
    else $error("Parser state not cleared after line terminator.");

  a_lb_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_bytes_r <= LB_FULL)
    else $error("Line byte counter exceeds its saturation value.");

  a_acc_loads: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("Accepted byte did not produce a result.");

  a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r != clt_pkg::KIND_END)) |->
      ((status_r == clt_pkg::STATUS_OK) && !has_args_r))
    else $error("Summary fields set on a non-terminator result.");

  a_overflow_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (line_bytes_r >= LB_FULL)) |=> (kind_r == clt_pkg::KIND_NONE) ||
      (kind_r == clt_pkg::KIND_END))
    else $error("Byte emitted while the line is in overflow.");

endmodule
